>>> rtl/touch_press_averager_assert.svh
// Assertion macros shared by the touch press averager RTL.
// Every macro expects clk and arst_n to be visible in the module that uses it.
`ifndef TOUCH_PRESS_AVERAGER_ASSERT_SVH
`define TOUCH_PRESS_AVERAGER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside of reset.
`define TPA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define TPA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPA_ASSERT(label, prop, msg)
`define TPA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> rtl/tpa_pkg.sv
`default_nettype none

package tpa_pkg;

	// Command that the front end hands to the back end for one sample.
	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_CONT    = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_DIV  = 2'd1,
		BK_OUT  = 2'd2
	} bk_state_t;

	// Fill status of the command queue.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	localparam int OP_W           = 2;
	localparam int ELAPSED_W      = 8;
	localparam int HOLD_W         = 16;
	localparam int DUR_W          = 16;
	localparam int FIFO_DEPTH     = 2;
	localparam logic [HOLD_W-1:0] HOLD_MS_RESET = 16'd1500;
	localparam logic [DUR_W-1:0]  DUR_MAX       = 16'hFFFF;

endpackage

`default_nettype wire

>>> rtl/tpa_front.sv
`default_nettype none

`include "touch_press_averager_assert.svh"

// Front end: tracks whether a press is open and turns each sample into a
// command for the back end. Idle samples are dropped here.
module tpa_front import tpa_pkg::*; #(
	parameter int COORD_BITS = 10,
	parameter int QW         = OP_W + 2 * COORD_BITS + ELAPSED_W
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire                   pressed,
	input  wire [COORD_BITS-1:0]  raw_x,
	input  wire [COORD_BITS-1:0]  raw_y,
	input  wire [ELAPSED_W-1:0]   elapsed_ms,
	input  q_status_t             q_status,
	output logic                  q_push,
	output logic [QW-1:0]         q_data
);

	logic active_q;
	logic take;
	op_t  op;

	// A sample is taken whenever the queue has room.
	assign in_ready = !q_status.full;
	assign take     = in_valid && in_ready;

	// Classify the sample against the open press.
	always_comb begin
		if (pressed && !active_q) begin
			op = OP_START;
		end else if (pressed) begin
			op = OP_CONT;
		end else begin
			op = OP_RELEASE;
		end
	end

	assign q_push = take && (pressed || active_q);
	assign q_data = {elapsed_ms, raw_y, raw_x, op};

	// Press tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (take) begin
			active_q <= pressed;
		end
	end

	`TPA_ASSERT(a_release_needs_press, q_push && (op == OP_RELEASE) |-> active_q, "release without open press")

endmodule

`default_nettype wire

>>> rtl/tpa_fifo.sv
`default_nettype none

`include "touch_press_averager_assert.svh"

// Short command queue between the front and back ends, first word fall-through.
module tpa_fifo import tpa_pkg::*; #(
	parameter int QW = 30
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  wire  [QW-1:0]  push_data,
	input  wire            pop,
	output logic [QW-1:0]  pop_data,
	output q_status_t      status
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [QW-1:0]    entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`TPA_ASSERT_ALWAYS(a_fifo_level, count_q <= CNT_W'(FIFO_DEPTH), "queue level above depth")

endmodule

`default_nettype wire

>>> rtl/tpa_div.sv
`default_nettype none

// Bit-serial restoring divider: one quotient bit per cycle. A zero divisor
// gives a zero quotient.
module tpa_div #(
	parameter int SUM_W      = 22,
	parameter int CNT_W      = 13,
	parameter int COORD_BITS = 10
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  wire  [SUM_W-1:0]       dividend,
	input  wire  [CNT_W-1:0]       divisor,
	output logic                   done,
	output logic [COORD_BITS-1:0]  quotient
);

	localparam int STEP_W = $clog2(SUM_W);

	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic              zero_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    shifted;
	logic [CNT_W:0]    diff;
	logic              ge;

	// One trial subtraction per cycle.
	assign shifted = {rem_q, dvd_q[SUM_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = (shifted >= {1'b0, dsr_q});

	assign done     = done_q;
	assign quotient = zero_q ? '0 : dvd_q[COORD_BITS-1:0];

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
		end
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/tpa_back.sv
`default_nettype none

`include "touch_press_averager_assert.svh"

// Back end: runs the commands of the queue on the press accumulators and, on
// release, divides the sums by the count and holds the result for the output.
module tpa_back import tpa_pkg::*; #(
	parameter int MAX_SAMPLES = 4096,
	parameter int COORD_BITS  = 10,
	parameter int QW          = OP_W + 2 * COORD_BITS + ELAPSED_W
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    hold_ms_we,
	input  wire  [HOLD_W-1:0]      hold_ms_wdata,
	input  q_status_t              q_status,
	input  wire  [QW-1:0]          q_data,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [COORD_BITS-1:0]  mean_x,
	output logic [COORD_BITS-1:0]  mean_y,
	output logic                   is_hold
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = COORD_BITS + CNT_W;

	bk_state_t            state_q;
	bk_state_t            state_d;
	logic [HOLD_W-1:0]    hold_ms_q;
	logic [SUM_W-1:0]     sum_x_q;
	logic [SUM_W-1:0]     sum_y_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DUR_W-1:0]     dur_q;
	logic                 hold_q;
	logic                 out_valid_q;
	logic [COORD_BITS-1:0] mean_x_q;
	logic [COORD_BITS-1:0] mean_y_q;
	logic                 is_hold_q;

	op_t                  op;
	logic [COORD_BITS-1:0] cmd_x;
	logic [COORD_BITS-1:0] cmd_y;
	logic [ELAPSED_W-1:0] cmd_el;
	logic [DUR_W:0]       dur_sum;
	logic [DUR_W-1:0]     dur_sat;
	logic                 div_start;
	logic                 out_load;
	logic                 div_x_done;
	logic                 div_y_done;
	logic [COORD_BITS-1:0] quo_x;
	logic [COORD_BITS-1:0] quo_y;

	// Command fields.
	assign op     = op_t'(q_data[OP_W-1:0]);
	assign cmd_x  = q_data[OP_W +: COORD_BITS];
	assign cmd_y  = q_data[OP_W + COORD_BITS +: COORD_BITS];
	assign cmd_el = q_data[OP_W + 2 * COORD_BITS +: ELAPSED_W];

	// Saturating duration update.
	assign dur_sum = {1'b0, dur_q} + (DUR_W + 1)'(cmd_el);
	assign dur_sat = dur_sum[DUR_W] ? DUR_MAX : dur_sum[DUR_W-1:0];

	// Sequencer: next state and control.
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop = !q_status.empty;
				if (q_pop && (op == OP_RELEASE)) begin
					div_start = 1'b1;
					state_d   = BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_x_done) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			hold_ms_q   <= HOLD_MS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (hold_ms_we) begin
				hold_ms_q <= hold_ms_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Press accumulators.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			case (op)
				OP_START: begin
					sum_x_q <= SUM_W'(cmd_x);
					sum_y_q <= SUM_W'(cmd_y);
					cnt_q   <= CNT_W'(1);
					dur_q   <= '0;
				end
				OP_CONT: begin
					dur_q <= dur_sat;
					if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
						sum_x_q <= sum_x_q + SUM_W'(cmd_x);
						sum_y_q <= sum_y_q + SUM_W'(cmd_y);
						cnt_q   <= cnt_q + 1'b1;
					end
				end
				OP_RELEASE: begin
					dur_q  <= dur_sat;
					hold_q <= (dur_sat >= hold_ms_q);
				end
				default: begin
					dur_q <= dur_q;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_x_q  <= quo_x;
			mean_y_q  <= quo_y;
			is_hold_q <= hold_q;
		end
	end

	// Both axes divide in lockstep.
	tpa_div #(
		.SUM_W      (SUM_W),
		.CNT_W      (CNT_W),
		.COORD_BITS (COORD_BITS)
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_x_q),
		.divisor  (cnt_q),
		.done     (div_x_done),
		.quotient (quo_x)
	);

	tpa_div #(
		.SUM_W      (SUM_W),
		.CNT_W      (CNT_W),
		.COORD_BITS (COORD_BITS)
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_y_q),
		.divisor  (cnt_q),
		.done     (div_y_done),
		.quotient (quo_y)
	);

	assign out_valid = out_valid_q;
	assign mean_x    = mean_x_q;
	assign mean_y    = mean_y_q;
	assign is_hold   = is_hold_q;

	`TPA_ASSERT(a_release_starts_div, div_start |=> state_q == BK_DIV, "release did not start division")
	`TPA_ASSERT(a_div_lockstep, div_x_done == div_y_done, "axis dividers out of step")
	`TPA_ASSERT(a_done_in_div, div_x_done |-> state_q == BK_DIV, "divider finished outside division")

endmodule

`default_nettype wire

>>> rtl/touch_press_averager.sv
// Channel  Dir  Transfer when          Payload
// s_*      in   s_tvalid & s_tready    tuser: pressed; tdata: raw_x, raw_y, elapsed_ms
// m_*      out  m_tvalid & m_tready    tuser: is_hold; tdata: mean_x, mean_y
// hold_ms  in   hold_ms_we             hold_ms_wdata: hold time in ms
//
// A press sample passes through the front end into the queue and is applied in the back
// end; an idle sample ends in the front end.
// A release sample runs the bit-serial dividers for mean X and Y in the back end, then
// moves its result to the output register.
// The two-entry command queue lets the front end take samples while a division runs;
// s_tready falls only when the queue is full.
// A result waits in the output register until taken; the next division can finish
// meanwhile and is held until the register frees up.
// arst_n clears the press state, the queue and the output; hold_ms returns to 1500.
`default_nettype none

module touch_press_averager import tpa_pkg::*; #(
	parameter int MAX_SAMPLES = 4096,
	parameter int COORD_BITS  = 10
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    hold_ms_we,
	input  wire  [HOLD_W-1:0]      hold_ms_wdata,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	// tdata: raw_x, raw_y, elapsed_ms, zero fill (lowest bit first)
	input  wire  [((2 * COORD_BITS + ELAPSED_W + 7) / 8) * 8 - 1:0] s_tdata,
	// tuser: pressed
	input  wire                    s_tuser,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	// tdata: mean_x, mean_y, zero fill (lowest bit first)
	output logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// tuser: is_hold
	output logic                   m_tuser
);

	localparam int QW    = OP_W + 2 * COORD_BITS + ELAPSED_W;
	localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;

	q_status_t             q_status;
	logic                  q_push;
	logic [QW-1:0]         q_push_data;
	logic                  q_pop;
	logic [QW-1:0]         q_pop_data;
	logic [COORD_BITS-1:0] mean_x;
	logic [COORD_BITS-1:0] mean_y;

	tpa_front #(
		.COORD_BITS (COORD_BITS),
		.QW         (QW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.pressed    (s_tuser),
		.raw_x      (s_tdata[COORD_BITS-1:0]),
		.raw_y      (s_tdata[2 * COORD_BITS - 1:COORD_BITS]),
		.elapsed_ms (s_tdata[2 * COORD_BITS + ELAPSED_W - 1:2 * COORD_BITS]),
		.q_status   (q_status),
		.q_push     (q_push),
		.q_data     (q_push_data)
	);

	tpa_fifo #(
		.QW (QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.status    (q_status)
	);

	tpa_back #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.COORD_BITS  (COORD_BITS),
		.QW          (QW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.hold_ms_we    (hold_ms_we),
		.hold_ms_wdata (hold_ms_wdata),
		.q_status      (q_status),
		.q_data        (q_pop_data),
		.q_pop         (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.mean_x        (mean_x),
		.mean_y        (mean_y),
		.is_hold       (m_tuser)
	);

	// Pack the means, zero filled to whole bytes.
	assign m_tdata = OUT_W'({mean_y, mean_x});

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import tpa_pkg::*;

	localparam int COORD_W            = 10;
	localparam int PRESS_SAMPLE_LIMIT = 4096;
	localparam int S_DATA_W           = ((2 * COORD_W + ELAPSED_W + 7) / 8) * 8;
	localparam int M_DATA_W           = ((2 * COORD_W + 7) / 8) * 8;
	// Settle time that covers a release in the back end with margin.
	localparam int SETTLE_CYCLES      = 64;
	localparam int CHUNK_SAMPLES      = 325;

	// One expected press result.
	typedef struct {
		logic [COORD_W-1:0] mean_x;
		logic [COORD_W-1:0] mean_y;
		bit                 is_hold;
	} press_result_t;

	// Tracks the press state and predicts the result of every release.
	class press_scoreboard;
		logic [HOLD_W-1:0]  hold_time;
		bit                 in_press;
		logic [21:0]        sum_x;
		logic [21:0]        sum_y;
		logic [12:0]        n_samples;
		logic [DUR_W-1:0]   press_ms;
		press_result_t      pending_results[$];
		int                 mismatches;
		int                 results_checked;
		int                 holds_seen;
		int                 samples_noted;

		function new();
			hold_time = HOLD_MS_RESET;
			in_press = 1'b0;
			sum_x = '0;
			sum_y = '0;
			n_samples = '0;
			press_ms = '0;
			mismatches = 0;
			results_checked = 0;
			holds_seen = 0;
			samples_noted = 0;
		endfunction

		function void set_hold_time(logic [HOLD_W-1:0] ms);
			hold_time = ms;
		endfunction

		// Duration saturates instead of wrapping.
		function void add_press_time(logic [ELAPSED_W-1:0] el);
			logic [DUR_W:0] total;
			total = {1'b0, press_ms} + (DUR_W + 1)'(el);
			press_ms = total[DUR_W] ? DUR_MAX : total[DUR_W-1:0];
		endfunction

		// Returns 1 for every pressed sample and for a release; 0 for an idle sample outside a press.
		function bit note_sample(bit pressed, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
				logic [ELAPSED_W-1:0] el);
			press_result_t res;
			samples_noted++;
			if (pressed) begin
				if (!in_press) begin
					in_press = 1'b1;
					sum_x = '0;
					sum_y = '0;
					n_samples = '0;
					press_ms = '0;
				end else begin
					add_press_time(el);
				end
				// Samples past the limit are dropped; the duration keeps running.
				if (n_samples < 13'(PRESS_SAMPLE_LIMIT)) begin
					sum_x = sum_x + 22'(x);
					sum_y = sum_y + 22'(y);
					n_samples = n_samples + 13'd1;
				end
				return 1'b1;
			end
			if (!in_press)
				return 1'b0;
			add_press_time(el);
			in_press = 1'b0;
			if (n_samples != '0) begin
				res.mean_x = COORD_W'(sum_x / 22'(n_samples));
				res.mean_y = COORD_W'(sum_y / 22'(n_samples));
			end else begin
				res.mean_x = '0;
				res.mean_y = '0;
			end
			res.is_hold = (press_ms >= hold_time);
			pending_results.push_back(res);
			return 1'b1;
		endfunction

		function void check_result(logic [COORD_W-1:0] mx, logic [COORD_W-1:0] my, bit hold);
			press_result_t exp_res;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected press result x=%0d y=%0d hold=%0d",
						$realtime, mx, my, hold);
				return;
			end
			exp_res = pending_results.pop_front();
			results_checked++;
			if (hold)
				holds_seen++;
			if (mx !== exp_res.mean_x || my !== exp_res.mean_y || hold !== exp_res.is_hold) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: press result %0d expected x=%0d y=%0d hold=%0d, got x=%0d y=%0d hold=%0d",
						$realtime, results_checked, exp_res.mean_x, exp_res.mean_y,
						exp_res.is_hold, mx, my, hold);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 hold_ms_we;
	logic [HOLD_W-1:0]    hold_ms_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	// tdata: raw_x, raw_y, elapsed_ms, zero fill (lowest bit first)
	logic [S_DATA_W-1:0]  s_tdata;
	// tuser: pressed
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// tdata: mean_x, mean_y, zero fill (lowest bit first)
	logic [M_DATA_W-1:0]  m_tdata;
	// tuser: is_hold
	logic                 m_tuser;

	press_scoreboard sb = new();
	int src_gap_pct;
	int sink_stall_pct;
	int effective_samples;

	touch_press_averager #(
		.MAX_SAMPLES (PRESS_SAMPLE_LIMIT),
		.COORD_BITS  (COORD_W)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.hold_ms_we    (hold_ms_we),
		.hold_ms_wdata (hold_ms_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

	// Free running clock, 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The result side stalls at random, changing at the falling edge.
	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= sink_stall_pct);
	end

	// Every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W], m_tuser);
	end

	// Backstop for a hung handshake.
	initial begin
		#6000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Offers one sample after random gaps and notes it once the transfer happens.
	task automatic drive_sample(input bit pressed, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [ELAPSED_W-1:0] el);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = pressed;
		s_tdata = '0;
		s_tdata[2*COORD_W+ELAPSED_W-1:0] = {el, y, x};
		do
			@(posedge clk);
		while (!s_tready);
		if (sb.note_sample(pressed, x, y, el))
			effective_samples++;
		@(negedge clk);
	endtask

	// Holds the sample side off until every predicted result has arrived.
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register writes happen only with the block idle.
	task automatic write_hold_time(input logic [HOLD_W-1:0] ms);
		wait_drained();
		hold_ms_we = 1'b1;
		hold_ms_wdata = ms;
		@(negedge clk);
		sb.set_hold_time(ms);
		hold_ms_we = 1'b0;
	endtask

	// Mostly complete presses with random shape, plus loose random samples.
	task automatic drive_random_presses(input int target);
		int start_count;
		int press_len;
		int pace;
		int cx;
		int cy;
		int tx;
		int ty;
		bit jitter_mode;
		logic [ELAPSED_W-1:0] el;
		start_count = effective_samples;
		while (effective_samples - start_count < target) begin
			if ($urandom_range(99) < 80) begin
				repeat ($urandom_range(2))
					drive_sample(1'b0, COORD_W'($urandom_range(1023)),
						COORD_W'($urandom_range(1023)), ELAPSED_W'($urandom_range(255)));
				pace = $urandom_range(2);
				case ($urandom_range(19))
					0: begin
						press_len = $urandom_range(320, 200);
						pace = 2;
					end
					1, 2, 3, 4, 5: press_len = $urandom_range(40, 9);
					default: press_len = $urandom_range(8, 1);
				endcase
				jitter_mode = 1'($urandom_range(1));
				cx = $urandom_range(1023);
				cy = $urandom_range(1023);
				for (int i = 0; i < press_len; i++) begin
					if (jitter_mode) begin
						tx = cx + $urandom_range(16) - 8;
						ty = cy + $urandom_range(16) - 8;
						tx = (tx < 0) ? 0 : (tx > 1023) ? 1023 : tx;
						ty = (ty < 0) ? 0 : (ty > 1023) ? 1023 : ty;
					end else begin
						tx = $urandom_range(1023);
						ty = $urandom_range(1023);
					end
					case (pace)
						0: el = ELAPSED_W'($urandom_range(255));
						1: el = ELAPSED_W'($urandom_range(20));
						default: el = ELAPSED_W'($urandom_range(255, 200));
					endcase
					drive_sample(1'b1, COORD_W'(tx), COORD_W'(ty), el);
				end
				drive_sample(1'b0, COORD_W'($urandom_range(1023)),
					COORD_W'($urandom_range(1023)), ELAPSED_W'($urandom_range(255)));
			end else begin
				drive_sample(1'($urandom_range(1)), COORD_W'($urandom_range(1023)),
					COORD_W'($urandom_range(1023)), ELAPSED_W'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		hold_ms_we = 1'b0;
		hold_ms_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		src_gap_pct = 28;
		sink_stall_pct = 74;
		effective_samples = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, at the reset hold time.
		// An idle sample with no press under way does nothing.
		drive_sample(1'b0, 10'd1023, 10'd1023, 8'd255);
		// Extremes of the coordinates; the elapsed time of the first sample is dropped.
		drive_sample(1'b1, 10'd0, 10'd0, 8'd255);
		drive_sample(1'b1, 10'd1023, 10'd1023, 8'd255);
		drive_sample(1'b0, 10'd0, 10'd0, 8'd0);
		// A single sample press at full scale.
		drive_sample(1'b1, 10'd1023, 10'd1023, 8'd0);
		drive_sample(1'b0, 10'd0, 10'd0, 8'd255);
		// Duration lands exactly on the hold time, then one millisecond short.
		drive_sample(1'b1, 10'd512, 10'd511, 8'd0);
		repeat (5) drive_sample(1'b1, 10'd341, 10'd682, 8'd255);
		drive_sample(1'b0, 10'd0, 10'd0, 8'd225);
		drive_sample(1'b1, 10'd1, 10'd2, 8'd0);
		repeat (5) drive_sample(1'b1, 10'd700, 10'd3, 8'd255);
		drive_sample(1'b0, 10'd0, 10'd0, 8'd224);

		// Sample side idles less than the result side.
		write_hold_time(16'd0);
		drive_random_presses(CHUNK_SAMPLES / 2);
		wait_drained();
		drive_random_presses(CHUNK_SAMPLES - CHUNK_SAMPLES / 2);
		write_hold_time(16'hFFFF);
		drive_random_presses(CHUNK_SAMPLES);

		// Result side idles less than the sample side.
		src_gap_pct = 74;
		sink_stall_pct = 28;
		write_hold_time(16'd1);
		drive_random_presses(CHUNK_SAMPLES);
		write_hold_time(16'd700);
		drive_random_presses(CHUNK_SAMPLES);

		// No idling on either side.
		src_gap_pct = 0;
		sink_stall_pct = 0;
		write_hold_time(HOLD_W'($urandom_range(65535, 1)));
		drive_random_presses(CHUNK_SAMPLES);
		write_hold_time(16'd3000);
		drive_random_presses(CHUNK_SAMPLES);

		// Let the last results out and make sure nothing extra follows.
		wait_drained();
		$display("Run covered %0d samples and %0d press results (%0d holds) over hold times",
			sb.samples_noted, sb.results_checked, sb.holds_seen);
		$display("from 0 to 65535, three idle mixes and long presses up to the duration cap.");
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches,
				sb.pending_results.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
